// ===== src/sch_pkg.sv =====
// shared types, constants and register codes for the salted crc64 key hash
package sch_pkg;

  localparam int unsigned HashW = 64;
  localparam int unsigned ByteW = 8;
  localparam int unsigned KeepNarrow = 28;
  localparam int unsigned KeepWide = 48;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned StepW = $clog2(HashW);

  typedef logic [HashW-1:0] sch_hash_t;
  typedef logic [HashW-1:0][HashW-1:0] sch_mat_t;

  localparam sch_hash_t SaltReset = 64'h0000_0000_0000_0001;
  localparam sch_hash_t PolyReset = 64'hC96C_5795_D787_0F42;

  // keep the top bits, clear the rest
  localparam sch_hash_t MaskNarrow = {HashW{1'b1}} << (HashW - KeepNarrow);
  localparam sch_hash_t MaskWide = {HashW{1'b1}} << (HashW - KeepWide);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSalt      = 3'd0,
    CfgPoly      = 3'd1,
    CfgWordKeys  = 3'd2,
    CfgPreHashed = 3'd3,
    CfgWideHash  = 3'd4
  } cfg_idx_e;

endpackage

// ===== src/sch_basis.sv =====
// builds the 64 crc basis vectors for the current polynomial, one shift per cycle
module sch_basis import sch_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      poly_we_i,
  input  sch_hash_t poly_i,
  output sch_mat_t  mat_o,
  output logic      busy_o
);

  sch_hash_t        poly_q;
  sch_mat_t         mat_q, mat_d;
  logic [StepW-1:0] step_q;
  logic             busy_q;

  // one reflected crc shift of every vector
  always_comb begin
    for (int j = 0; j < HashW; j++) begin
      mat_d[j] = {1'b0, mat_q[j][HashW-1:1]} ^ (mat_q[j][0] ? poly_q : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
      busy_q <= 1'b1;
      step_q <= '0;
      for (int j = 0; j < HashW; j++) begin
        mat_q[j] <= sch_hash_t'(1) << j;
      end
    end else if (poly_we_i) begin
      poly_q <= poly_i;
      busy_q <= 1'b1;
      step_q <= '0;
      for (int j = 0; j < HashW; j++) begin
        mat_q[j] <= sch_hash_t'(1) << j;
      end
    end else if (busy_q) begin
      mat_q  <= mat_d;
      step_q <= step_q + 1'b1;
      if (step_q == StepW'(HashW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign mat_o  = mat_q;
  assign busy_o = busy_q;

endmodule

// ===== src/sch_fold.sv =====
// folds one byte or one word into the running hash as an xor network
module sch_fold import sch_pkg::*; (
  input  sch_hash_t h_i,
  input  sch_hash_t elem_i,
  input  logic      word_i,
  input  sch_mat_t  mat_i,
  output sch_hash_t h_o
);

  sch_hash_t              x;
  sch_hash_t              word_res;
  sch_hash_t              byte_res;
  logic [HashW-1:0][HashW-1:0] col;
  logic [HashW-1:0][ByteW-1:0] col_b;

  assign x = h_i ^ elem_i;

  // columns of the basis; the top byte rows are the single-byte table basis
  always_comb begin
    for (int b = 0; b < HashW; b++) begin
      for (int j = 0; j < HashW; j++) begin
        col[b][j] = mat_i[j][b];
      end
      for (int i = 0; i < ByteW; i++) begin
        col_b[b][i] = mat_i[HashW-ByteW+i][b];
      end
    end
  end

  always_comb begin
    for (int b = 0; b < HashW; b++) begin
      word_res[b] = ^(x & col[b]);
      byte_res[b] = ^(x[ByteW-1:0] & col_b[b]);
    end
  end

  assign h_o = word_i ? word_res : ((h_i >> ByteW) ^ byte_res);

endmodule

// ===== src/salted_crc64_key_hash_core.sv =====
// top level of the salted crc64 key hash: config registers, item stage and result register
//
//  channel  dir  handshake                  payload
//  in       in   in_valid_i / in_ready_o    key_element_i, has_data_i, last_i
//  out      out  out_valid_o / out_ready_i  hash_value_o
//  cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one request per cycle while the basis unit is idle and no last request is held back;
// a request is registered into the item stage, where the fold network runs, and a last
// request then moves on into the result register; after reset and after every polynomial
// write the basis unit runs a pass (one crc shift per cycle) and in_ready_o stays low
// until the pass ends; a last request waits in the item stage while the result register
// is held full; other requests pass through it since they make no result
// cfg_ready_o is always high
module salted_crc64_key_hash_core import sch_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [HashW-1:0]   key_element_i,
  input  logic               has_data_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [HashW-1:0]   hash_value_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [HashW-1:0]   cfg_data_i
);

  // configuration registers (polynomial lives in the basis unit)
  sch_hash_t salt_q;
  logic      word_keys_q;
  logic      pre_hashed_q;
  logic      wide_hash_q;

  // key state
  sch_hash_t run_q, run_d;
  logic      started_q, started_d;

  // item stage
  logic      s1_valid_q;
  sch_hash_t key_q;
  logic      has_q;
  logic      last_q;

  // result register
  logic      out_valid_q;
  sch_hash_t hash_q;

  sch_mat_t  mat;
  logic      bas_busy;
  logic      cfg_acc;
  logic      in_acc;
  logic      s1_adv;
  sch_hash_t fold_in;
  sch_hash_t fold_out;
  sch_hash_t fin_hash;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      salt_q       <= SaltReset;
      word_keys_q  <= 1'b0;
      pre_hashed_q <= 1'b0;
      wide_hash_q  <= 1'b0;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        CfgSalt:      salt_q       <= cfg_data_i;
        CfgWordKeys:  word_keys_q  <= cfg_data_i[0];
        CfgPreHashed: pre_hashed_q <= cfg_data_i[0];
        CfgWideHash:  wide_hash_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // basis vectors of the crc for the current polynomial
  sch_basis u_basis (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .poly_we_i (cfg_acc && (cfg_index_i == CfgPoly)),
    .poly_i    (cfg_data_i),
    .mat_o     (mat),
    .busy_o    (bas_busy)
  );

  // a last request only leaves the stage when the result register can take it
  assign s1_adv     = s1_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !bas_busy && (!s1_valid_q || s1_adv);
  assign in_acc     = in_valid_i && in_ready_o;

  // salt is read only at key start
  assign fold_in = started_q ? run_q : salt_q;

  sch_fold u_fold (
    .h_i    (fold_in),
    .elem_i (key_q),
    .word_i (word_keys_q),
    .mat_i  (mat),
    .h_o    (fold_out)
  );

  // key state update and finishing
  always_comb begin
    run_d     = run_q;
    started_d = started_q;
    if (has_q) begin
      if (pre_hashed_q) begin
        // first word is the hash, later words ignored
        if (!started_q) begin
          run_d = key_q;
        end
      end else begin
        run_d = fold_out;
      end
      started_d = 1'b1;
    end
    // empty key gives the salt, or zero when pre-hashed
    fin_hash = started_d ? run_d : (pre_hashed_q ? '0 : salt_q);
    if (last_q) begin
      run_d     = fin_hash;
      started_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      run_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        run_q     <= run_d;
        started_q <= started_d;
      end
      if (s1_adv && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q  <= key_element_i;
      has_q  <= has_data_i;
      last_q <= last_i;
    end
    if (s1_adv && last_q) begin
      hash_q <= fin_hash & (wide_hash_q ? MaskWide : MaskNarrow);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

`ifndef SYNTHESIS
  // no request is taken while the basis is being rebuilt
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bas_busy |-> !in_ready_o)
    else $error("request accepted during basis pass");

  // at least the low 16 bits are always cleared
  a_low_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hash_value_o[HashW-KeepWide-1:0] == '0))
    else $error("result has low bits set");

  // a last request waits while the result register is held
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && last_q && out_valid_q && !out_ready_i) |=> s1_valid_q)
    else $error("last request dropped under stall");

  // a finished key leaves no key in progress
  a_key_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && last_q) |=> !started_q)
    else $error("key still open after last");
`endif

endmodule

// ===== tb/salted_crc64_key_hash_core_tb.sv =====
// testbench for the salted crc64 key hash core: directed table, random keys, hash predictor
`timescale 1ns / 1ps

module salted_crc64_key_hash_core_tb;
  import sch_pkg::*;

  localparam int unsigned NumPhases = 10;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldPhase = 3;
  localparam int unsigned PausePhase = 6;
  localparam int unsigned CycleLimit = 500000;
  localparam sch_hash_t AllOnes = '1;

  typedef enum logic {RowItem, RowWrite} row_kind_e;

  // one directed step: a request, or a register write between requests
  typedef struct packed {
    row_kind_e kind;
    cfg_idx_e  reg_idx;
    sch_hash_t value;    // key element, or register data
    logic      has_data;
    logic      last;
    logic      typed;    // hash below is read straight off the spec
    sch_hash_t hash;
  } plan_row_t;

  localparam int unsigned PlanLen = 29;
  localparam plan_row_t Plan [PlanLen] = '{
    // reset config: salt 1, default polynomial, byte keys, 28-bit hash
    '{RowItem,  CfgSalt,      64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0, 1'b0, '0},
    '{RowItem,  CfgSalt,      64'h0,                   1'b0, 1'b1, 1'b1, 64'h0},
    '{RowItem,  CfgSalt,      64'hFFFF_FFFF_FFFF_FF00, 1'b1, 1'b0, 1'b0, '0},
    '{RowItem,  CfgSalt,      64'h0000_0000_0000_00FF, 1'b1, 1'b1, 1'b0, '0},
    '{RowItem,  CfgSalt,      64'h0,                   1'b1, 1'b1, 1'b0, '0},
    '{RowWrite, CfgWideHash,  64'h1,                   1'b0, 1'b0, 1'b0, '0},
    '{RowWrite, CfgSalt,      AllOnes,                 1'b0, 1'b0, 1'b0, '0},
    // empty key gives the salt, wide mask
    '{RowItem,  CfgSalt,      64'h0,                   1'b0, 1'b1, 1'b1,
      64'hFFFF_FFFF_FFFF_0000},
    '{RowItem,  CfgSalt,      AllOnes,                 1'b1, 1'b1, 1'b0, '0},
    '{RowWrite, CfgPreHashed, 64'h1,                   1'b0, 1'b0, 1'b0, '0},
    // pre-hashed empty key is zero
    '{RowItem,  CfgSalt,      64'h0,                   1'b0, 1'b1, 1'b1, 64'h0},
    // pre-hashed: first word is the hash, the second one is dropped
    '{RowItem,  CfgSalt,      AllOnes,                 1'b1, 1'b0, 1'b0, '0},
    '{RowItem,  CfgSalt,      64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 1'b1,
      64'hFFFF_FFFF_FFFF_0000},
    // key closed by a last request without data
    '{RowItem,  CfgSalt,      64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 1'b0, 1'b0, '0},
    '{RowItem,  CfgSalt,      64'h0,                   1'b0, 1'b1, 1'b1,
      64'hA5A5_A5A5_A5A5_0000},
    '{RowWrite, CfgWideHash,  64'h0,                   1'b0, 1'b0, 1'b0, '0},
    '{RowItem,  CfgSalt,      AllOnes,                 1'b1, 1'b1, 1'b1,
      64'hFFFF_FFF0_0000_0000},
    '{RowWrite, CfgPreHashed, 64'h0,                   1'b0, 1'b0, 1'b0, '0},
    '{RowWrite, CfgWordKeys,  64'h1,                   1'b0, 1'b0, 1'b0, '0},
    '{RowWrite, CfgPoly,      64'h0,                   1'b0, 1'b0, 1'b0, '0},
    // zero polynomial just shifts the hash out, eight bytes leave nothing
    '{RowItem,  CfgSalt,      AllOnes,                 1'b1, 1'b1, 1'b1, 64'h0},
    '{RowWrite, CfgPoly,      AllOnes,                 1'b0, 1'b0, 1'b0, '0},
    '{RowItem,  CfgSalt,      AllOnes,                 1'b1, 1'b0, 1'b0, '0},
    '{RowItem,  CfgSalt,      64'h0,                   1'b1, 1'b1, 1'b0, '0},
    // switch from word to byte keys in the middle of a key
    '{RowItem,  CfgSalt,      64'h8000_0000_0000_0001, 1'b1, 1'b0, 1'b0, '0},
    '{RowWrite, CfgWordKeys,  64'h0,                   1'b0, 1'b0, 1'b0, '0},
    '{RowItem,  CfgSalt,      64'h0000_0000_0000_005A, 1'b1, 1'b1, 1'b0, '0},
    '{RowWrite, CfgPoly,      PolyReset,               1'b0, 1'b0, 1'b0, '0},
    '{RowWrite, CfgSalt,      SaltReset,               1'b0, 1'b0, 1'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [HashW-1:0]   key_element_i;
  logic               has_data_i;
  logic               last_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [HashW-1:0]   hash_value_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [HashW-1:0]   cfg_data_i;

  // register copies and key state of the predictor
  sch_hash_t cfg_salt;
  sch_hash_t cfg_poly;
  logic      cfg_word_keys;
  logic      cfg_pre_hashed;
  logic      cfg_wide_hash;
  sch_hash_t run_hash;
  logic      key_open;

  sch_hash_t pending_hash_q[$];

  int unsigned n_requests;
  int unsigned n_key_items;
  int unsigned n_hashes;
  int unsigned n_reg_writes;
  int unsigned n_mismatch;
  int unsigned n_cycles;

  // traffic shaping shared between the sender and the receiver
  bit gaps_on;
  bit stalls_on;
  bit calm;
  bit sink_hold;

  salted_crc64_key_hash_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_element_i (key_element_i),
    .has_data_i    (has_data_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hash_value_o  (hash_value_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // reflected crc64 update by one byte under the current polynomial
  function automatic sch_hash_t crc64_fold_byte(sch_hash_t h, logic [ByteW-1:0] b);
    sch_hash_t t;
    t = sch_hash_t'(h[ByteW-1:0] ^ b);
    for (int k = 0; k < ByteW; k++) t = t[0] ? ((t >> 1) ^ cfg_poly) : (t >> 1);
    return (h >> ByteW) ^ t;
  endfunction

  // advance the key state by one request; a last request yields the masked hash
  task automatic key_hash_step(input sch_hash_t elem, input logic dat, input logic lst,
                               output logic got, output sch_hash_t res);
    sch_hash_t h;
    got = 1'b0;
    res = '0;
    if (dat) begin
      if (cfg_pre_hashed) begin
        if (!key_open) run_hash = elem;
      end else begin
        h = key_open ? run_hash : cfg_salt;
        if (cfg_word_keys) begin
          for (int j = 0; j < HashW / ByteW; j++) h = crc64_fold_byte(h, elem[ByteW*j +: ByteW]);
        end else begin
          h = crc64_fold_byte(h, elem[ByteW-1:0]);
        end
        run_hash = h;
      end
      key_open = 1'b1;
    end
    if (lst) begin
      h = key_open ? run_hash : (cfg_pre_hashed ? '0 : cfg_salt);
      res = h & (cfg_wide_hash ? MaskWide : MaskNarrow);
      run_hash = h;
      key_open = 1'b0;
      got = 1'b1;
    end
  endtask

  function automatic sch_hash_t rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return AllOnes;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // valid stays up after acceptance; the next call or the caller lowers it
  task automatic send_request(input sch_hash_t elem, input logic dat, input logic lst,
                              input logic typed, input sch_hash_t typed_hash);
    logic      got;
    sch_hash_t h;
    if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    key_element_i <= elem;
    has_data_i    <= dat;
    last_i        <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    n_requests++;
    key_hash_step(elem, dat, lst, got, h);
    if (got) pending_hash_q.push_back(typed ? typed_hash : h);
  endtask

  // registers change only with nothing in flight
  task automatic write_register(input cfg_idx_e idx, input sch_hash_t val);
    in_valid_i <= 1'b0;
    while (pending_hash_q.size() != 0) @(posedge clk_i);
    // requests without a result may still sit in the item stage
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgSalt:      cfg_salt = val;
      CfgPoly:      cfg_poly = val;
      CfgWordKeys:  cfg_word_keys = val[0];
      CfgPreHashed: cfg_pre_hashed = val[0];
      CfgWideHash:  cfg_wide_hash = val[0];
      default: ;
    endcase
    n_reg_writes++;
  endtask

  // one key: data requests with stray no-data requests mixed in, closed by a last
  task automatic send_key(input int unsigned max_len, inout int unsigned cnt);
    int unsigned len;
    bit          end_plain;
    len = $urandom_range(0, max_len);
    end_plain = (len == 0) || ($urandom_range(0, 4) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) send_request(rand_word(), 1'b0, 1'b0, 1'b0, '0);
      send_request(rand_word(), 1'b1, (i == len - 1) && !end_plain, 1'b0, '0);
      cnt++;
    end
    if (end_plain) begin
      send_request(rand_word(), 1'b0, 1'b1, 1'b0, '0);
      cnt++;
    end
  endtask

  // receiver: random stall bursts, one long hold on request, none at the end
  initial begin : sink_proc
    forever begin
      if (sink_hold) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        sink_hold = 1'b0;
      end else if (stalls_on && !calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // compare every hash against the oldest outstanding one
  always @(posedge clk_i) begin : hash_check
    sch_hash_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_hashes++;
      if (pending_hash_q.size() == 0) begin
        $display("%0t: unexpected hash, expected none, actual %h", $time, hash_value_o);
        n_mismatch++;
      end else begin
        want = pending_hash_q.pop_front();
        if (hash_value_o !== want) begin
          $display("%0t: hash_value mismatch, expected %h, actual %h",
                   $time, want, hash_value_o);
          n_mismatch++;
        end
      end
    end
  end

  initial begin : watchdog
    n_cycles = 0;
    while (n_cycles < CycleLimit) begin
      @(posedge clk_i);
      n_cycles++;
    end
    $display("timeout after %0d cycles, %0d hashes outstanding",
             n_cycles, pending_hash_q.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_items;
    int unsigned tail;
    bit          paused;
    sch_hash_t   salt_val;
    sch_hash_t   poly_val;

    n_requests = 0;
    n_key_items = 0;
    n_hashes = 0;
    n_reg_writes = 0;
    n_mismatch = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    calm = 1'b0;
    sink_hold = 1'b0;
    cfg_salt = SaltReset;
    cfg_poly = PolyReset;
    cfg_word_keys = 1'b0;
    cfg_pre_hashed = 1'b0;
    cfg_wide_hash = 1'b0;
    run_hash = '0;
    key_open = 1'b0;

    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    key_element_i <= '0;
    has_data_i    <= 1'b0;
    last_i        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CfgSalt;
    cfg_data_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int unsigned r = 0; r < PlanLen; r++) begin
      if (Plan[r].kind == RowWrite) begin
        write_register(Plan[r].reg_idx, Plan[r].value);
      end else begin
        send_request(Plan[r].value, Plan[r].has_data, Plan[r].last,
                     Plan[r].typed, Plan[r].hash);
        n_key_items++;
      end
    end

    // random keys under a new register setting per phase
    paused = 1'b0;
    for (int unsigned p = 0; p < NumPhases; p++) begin
      calm = (p == NumPhases - 1);
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;

      salt_val = {$urandom, $urandom};
      if (salt_val == '0) salt_val = SaltReset;
      if (p == 0) salt_val = SaltReset;
      if (p == 1) salt_val = AllOnes;
      poly_val = {$urandom, $urandom};
      if (p == 0) poly_val = PolyReset;
      if (p == 2) poly_val = '0;
      if (p == 3) poly_val = AllOnes;

      write_register(CfgSalt, salt_val);
      write_register(CfgPoly, poly_val);
      write_register(CfgWordKeys, (p < 8) ? sch_hash_t'(p & 1) : sch_hash_t'($urandom_range(0, 1)));
      write_register(CfgPreHashed, sch_hash_t'((p == 4) || (p == 7)));
      write_register(CfgWideHash, (p < 8) ? sch_hash_t'((p >> 1) & 1)
                                          : sch_hash_t'($urandom_range(0, 1)));

      // long receiver hold while keys keep coming: the core has to back up
      if (p == HoldPhase) sink_hold = 1'b1;

      phase_items = 0;
      while (phase_items < PhaseItems) begin
        if (p == PausePhase && !paused && phase_items >= PhaseItems / 2) begin
          // sender goes quiet until every outstanding hash is out
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (pending_hash_q.size() != 0);
          paused = 1'b1;
        end
        send_key(cfg_word_keys ? 4 : 12, phase_items);
      end

      // sometimes leave a key open so the next setting applies mid-key
      if (!calm && $urandom_range(0, 1) == 1) begin
        tail = $urandom_range(1, 3);
        for (int unsigned i = 0; i < tail; i++) begin
          send_request(rand_word(), 1'b1, 1'b0, 1'b0, '0);
          phase_items++;
        end
      end
      n_key_items += phase_items;
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_hash_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run: %0d requests (%0d key items), %0d hashes checked, %0d register writes",
             n_requests, n_key_items, n_hashes, n_reg_writes);
    $display("run: byte, word and pre-hashed keys over %0d settings, both masks, %0d mismatches",
             NumPhases, n_mismatch);
    if (n_mismatch == 0 && pending_hash_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sch_pkg.sv
src/sch_basis.sv
src/sch_fold.sv
src/salted_crc64_key_hash_core.sv
tb/salted_crc64_key_hash_core_tb.sv
